// ===== hw/rtl/qrs_pkg.sv =====
// shared types and constants for the quadratic root solver
package qrs_pkg;

  localparam int ROOT_FRAC_BITS_DEF = 16;
  localparam int COEF_W = 16;
  localparam int ROOT_W = 32;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]               root_count;
    logic signed [ROOT_W-1:0] root_first;
    logic signed [ROOT_W-1:0] root_second;
    logic                     root_saturated;
  } qrs_out_t;

endpackage

// ===== hw/rtl/qrs_sqrt_cell.sv =====
// one digit cell of the pipelined square root chain
module qrs_sqrt_cell import qrs_pkg::*; #(
  parameter int RW = 33,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            v_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [SW-1:0]   side_i,
  output logic            v_o,
  output logic [2*RW-1:0] rad_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [RW+3:0] rem_sh;
  logic [RW+3:0] trial;
  logic [RW+3:0] rem_next;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_i, rad_i[2*RW-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    ge       = rem_sh >= trial;
    rem_next = ge ? rem_sh - trial : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      rem_o  <= rem_next[RW+1:0];
      root_o <= {root_i[RW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

// ===== hw/rtl/qrs_div_cell.sv =====
// one quotient bit cell of the pipelined restoring divider chain
module qrs_div_cell import qrs_pkg::*; #(
  parameter int MW = 34,
  parameter int DW = 17,
  parameter int SW = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_i,
  input  logic [MW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] d_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [MW-1:0] num_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] d_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0] rem_sh;
  logic [DW:0] rem_next;
  logic        ge;

  always_comb begin
    rem_sh   = {rem_i, num_i[MW-1]};
    ge       = rem_sh >= {1'b0, d_i};
    rem_next = ge ? rem_sh - {1'b0, d_i} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o  <= {num_i[MW-2:0], ge};
      rem_o  <= rem_next[DW-1:0];
      d_o    <= d_i;
      side_o <= side_i;
    end
  end

endmodule

// ===== hw/rtl/quadratic_root_solver.sv =====
// top level of the quadratic root solver: coefficient stages, root and divider chains
// Takes one equation per cycle unless the output stalls; an equation passes through two
// coefficient stages, one square root cell per root bit (ROOT_FRAC_BITS + 17), one setup
// stage, one divider cell per quotient bit in each of two chains (ROOT_FRAC_BITS + 18)
// and the output register. The whole pipeline advances when the output register is
// empty or being taken, so coef_ready follows root_ready.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int ROOT_FRAC_BITS = ROOT_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     coef_valid,
  output logic     coef_ready,
  input  qrs_in_t  coef,
  output logic     root_valid,
  input  logic     root_ready,
  output qrs_out_t root
);

  localparam int R    = ROOT_FRAC_BITS;
  localparam int NW   = R + 19;
  localparam int MW   = R + 18;
  localparam int DW   = 17;
  localparam int RW   = R + 17;
  localparam int RADW = 2 * RW;
  localparam int SSW  = NW + 20;
  localparam int QW   = (MW > ROOT_W) ? MW : ROOT_W + 1;

  logic en;
  assign en = !root_valid || root_ready;
  assign coef_ready = en;

  // stage 1: products
  logic               v1;
  logic signed [31:0] bb1, ac1;
  logic signed [15:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= coef_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb1 <= coef.coef_b * coef.coef_b;
      ac1 <= coef.coef_a * coef.coef_c;
      a1  <= coef.coef_a;
      b1  <= coef.coef_b;
      c1  <= coef.coef_c;
    end
  end

  // stage 2: discriminant and classification
  logic signed [34:0]   disc;
  logic [1:0]           cnt_next;
  logic signed [NW-1:0] num_next;
  logic signed [17:0]   den_next;
  logic [RADW-1:0]      rad_next;
  logic                 v2;
  logic [1:0]           cnt2;
  logic signed [NW-1:0] num2;
  logic signed [17:0]   den2;
  logic [RADW-1:0]      rad2;

  always_comb begin
    disc     = {{3{bb1[31]}}, bb1} - {ac1[31], ac1, 2'b00};
    rad_next = '0;
    if (a1 == 16'sd0) begin
      num_next = (-NW'(c1)) <<< R;
      den_next = 18'(b1);
      if (b1 != 16'sd0) begin
        cnt_next = CNT_ONE;
      end else if (c1 == 16'sd0) begin
        cnt_next = CNT_INF;
      end else begin
        cnt_next = CNT_NONE;
      end
    end else begin
      num_next = (-NW'(b1)) <<< R;
      den_next = 18'(a1) <<< 1;
      if (disc > 35'sd0) begin
        cnt_next = CNT_TWO;
        rad_next = RADW'(disc[33:0]) << (2 * R);
      end else if (disc == 35'sd0) begin
        cnt_next = CNT_ONE;
      end else begin
        cnt_next = CNT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt2 <= cnt_next;
      num2 <= num_next;
      den2 <= den_next;
      rad2 <= rad_next;
    end
  end

  // square root chain
  logic            sq_v    [RW+1];
  logic [RADW-1:0] sq_rad  [RW+1];
  logic [RW+1:0]   sq_rem  [RW+1];
  logic [RW-1:0]   sq_root [RW+1];
  logic [SSW-1:0]  sq_side [RW+1];

  assign sq_v[0]    = v2;
  assign sq_rad[0]  = rad2;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {cnt2, den2, num2};

  for (genvar i = 0; i < RW; i++) begin : g_sq
    qrs_sqrt_cell #(.RW(RW), .SW(SSW)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_i   (sq_v[i]),
      .rad_i (sq_rad[i]),
      .rem_i (sq_rem[i]),
      .root_i(sq_root[i]),
      .side_i(sq_side[i]),
      .v_o   (sq_v[i+1]),
      .rad_o (sq_rad[i+1]),
      .rem_o (sq_rem[i+1]),
      .root_o(sq_root[i+1]),
      .side_o(sq_side[i+1])
    );
  end

  // stage 3: numerators, magnitudes and signs
  logic [1:0]           cnt_s;
  logic signed [17:0]   den_s;
  logic signed [NW-1:0] num_s, sx, n1, n2, m1, m2;
  logic signed [17:0]   dm;
  logic                 v3;
  logic [1:0]           cnt3;
  logic                 neg1_3, neg2_3;
  logic [MW-1:0]        mag1_3, mag2_3;
  logic [DW-1:0]        dmag3;

  always_comb begin
    {cnt_s, den_s, num_s} = sq_side[RW];
    sx = NW'({1'b0, sq_root[RW]});
    n1 = num_s + sx;
    n2 = num_s - sx;
    m1 = n1[NW-1] ? -n1 : n1;
    m2 = n2[NW-1] ? -n2 : n2;
    dm = den_s[17] ? -den_s : den_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= sq_v[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt3   <= cnt_s;
      neg1_3 <= n1[NW-1] ^ den_s[17];
      neg2_3 <= n2[NW-1] ^ den_s[17];
      mag1_3 <= m1[MW-1:0];
      mag2_3 <= m2[MW-1:0];
      dmag3  <= dm[DW-1:0];
    end
  end

  // divider chains
  logic          d1_v    [MW+1];
  logic [MW-1:0] d1_num  [MW+1];
  logic [DW-1:0] d1_rem  [MW+1];
  logic [DW-1:0] d1_d    [MW+1];
  logic [3:0]    d1_side [MW+1];
  logic          d2_v    [MW+1];
  logic [MW-1:0] d2_num  [MW+1];
  logic [DW-1:0] d2_rem  [MW+1];
  logic [DW-1:0] d2_d    [MW+1];
  logic [0:0]    d2_side [MW+1];

  assign d1_v[0]    = v3;
  assign d1_num[0]  = mag1_3;
  assign d1_rem[0]  = '0;
  assign d1_d[0]    = dmag3;
  assign d1_side[0] = {cnt3, neg1_3, neg2_3};
  assign d2_v[0]    = v3;
  assign d2_num[0]  = mag2_3;
  assign d2_rem[0]  = '0;
  assign d2_d[0]    = dmag3;
  assign d2_side[0] = neg2_3;

  for (genvar i = 0; i < MW; i++) begin : g_div
    qrs_div_cell #(.MW(MW), .DW(DW), .SW(4)) u_first (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_i   (d1_v[i]),
      .num_i (d1_num[i]),
      .rem_i (d1_rem[i]),
      .d_i   (d1_d[i]),
      .side_i(d1_side[i]),
      .v_o   (d1_v[i+1]),
      .num_o (d1_num[i+1]),
      .rem_o (d1_rem[i+1]),
      .d_o   (d1_d[i+1]),
      .side_o(d1_side[i+1])
    );
    qrs_div_cell #(.MW(MW), .DW(DW), .SW(1)) u_second (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_i   (d2_v[i]),
      .num_i (d2_num[i]),
      .rem_i (d2_rem[i]),
      .d_i   (d2_d[i]),
      .side_i(d2_side[i]),
      .v_o   (d2_v[i+1]),
      .num_o (d2_num[i+1]),
      .rem_o (d2_rem[i+1]),
      .d_o   (d2_d[i+1]),
      .side_o(d2_side[i+1])
    );
  end

  // final: sign, saturation, unused roots
  logic [1:0]        cnt_f;
  logic              neg1_f, neg2_f, neg2_alt;
  logic [QW-1:0]     q1, q2;
  logic              big1, big2, sat1, sat2, use1, use2;
  logic [ROOT_W-1:0] r1, r2;
  qrs_out_t          root_next;

  always_comb begin
    {cnt_f, neg1_f, neg2_alt} = d1_side[MW];
    neg2_f = d2_side[MW][0];
    q1 = QW'(d1_num[MW]);
    q2 = QW'(d2_num[MW]);
    big1 = q1[QW-1:ROOT_W] != '0;
    big2 = q2[QW-1:ROOT_W] != '0;
    sat1 = big1 || (neg1_f ? (q1[31] && q1[30:0] != '0) : q1[31]);
    sat2 = big2 || (neg2_f ? (q2[31] && q2[30:0] != '0) : q2[31]);
    r1 = sat1 ? (neg1_f ? 32'h8000_0000 : 32'h7fff_ffff)
              : (neg1_f ? -q1[31:0] : q1[31:0]);
    r2 = sat2 ? (neg2_f ? 32'h8000_0000 : 32'h7fff_ffff)
              : (neg2_f ? -q2[31:0] : q2[31:0]);
    use1 = (cnt_f == CNT_ONE) || (cnt_f == CNT_TWO);
    use2 = (cnt_f == CNT_TWO) && (neg2_alt == neg2_f);
    root_next.root_count     = cnt_f;
    root_next.root_first     = use1 ? r1 : '0;
    root_next.root_second    = use2 ? r2 : '0;
    root_next.root_saturated = (use1 && sat1) || (use2 && sat2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (en) begin
      root_valid <= d1_v[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= root_next;
    end
  end

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    root_valid && (root.root_count == CNT_NONE || root.root_count == CNT_INF)
    |-> root.root_first == '0 && root.root_second == '0 && !root.root_saturated)
    else $error("roots present without a root");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    root_valid && root.root_count != CNT_TWO |-> root.root_second == '0)
    else $error("second root without two roots");

  a_two_rad: assert property (@(posedge clk) disable iff (rst)
    v2 && cnt2 == CNT_TWO |-> rad2 != '0)
    else $error("two roots with empty radicand");

  a_chain_sync: assert property (@(posedge clk) disable iff (rst)
    d1_v[MW] == d2_v[MW])
    else $error("divider chains out of step");

endmodule
